// ===== sv/mer_pkg.sv =====
`timescale 1ns / 1ps

package mer_pkg;

  localparam int COORD_BITS_DEF  = 12;
  localparam int RADIUS_BITS_DEF = 11;

  // Width of the midpoint decision variable (two's complement, wraps).
  localparam int DEC_BITS = 48;

endpackage

// ===== sv/mer_ifs.sv =====
`timescale 1ns / 1ps

interface mer_cmd_if #(
  parameter int COORD_BITS  = mer_pkg::COORD_BITS_DEF,
  parameter int RADIUS_BITS = mer_pkg::RADIUS_BITS_DEF
);
  logic                   valid;
  logic                   ready;
  logic                   action;
  logic [COORD_BITS-1:0]  centre_x;
  logic [COORD_BITS-1:0]  centre_y;
  logic [RADIUS_BITS-1:0] radius_x;
  logic [RADIUS_BITS-1:0] radius_y;

  modport source (
    output valid, action, centre_x, centre_y, radius_x, radius_y,
    input  ready
  );
  modport sink (
    input  valid, action, centre_x, centre_y, radius_x, radius_y,
    output ready
  );
endinterface

interface mer_pix_if #(
  parameter int COORD_BITS = mer_pkg::COORD_BITS_DEF
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS+1:0] pixel_x;
  logic signed [COORD_BITS+1:0] pixel_y;
  logic                         point_last;
  logic                         ellipse_done;

  modport source (
    output valid, pixel_x, pixel_y, point_last, ellipse_done,
    input  ready
  );
  modport sink (
    input  valid, pixel_x, pixel_y, point_last, ellipse_done,
    output ready
  );
endinterface

// ===== sv/midpoint_ellipse_rasterizer_core.sv =====
`timescale 1ns / 1ps

// Midpoint ellipse rasterizer.
// cmd channel (valid/ready): action 0 loads centre and semi-axes (no pixels),
// action 1 produces the four mirrored pixels of the current first-quadrant point
// on the pix channel, in the order (+x,-y) (-x,+y) (+x,+y) (-x,-y), then steps on.
// point_last marks the fourth pixel of a point, ellipse_done the fourth pixel of
// the point at y = 0. Steps after the ellipse is finished produce nothing.
// All multiplications go through one registered multiplier under a small sequencer,
// so cmd is taken only when the sequencer is back in its ready state. Pixel
// emission produces one pixel per cycle while the receiver takes them. pix has
// an output register, so a new cmd can be taken while the last pixel waits; a
// stalled receiver stretches the emission.
// Synchronous reset returns to the ready state with no ellipse loaded and pix idle.
module midpoint_ellipse_rasterizer_core #(
  parameter int COORD_BITS  = mer_pkg::COORD_BITS_DEF,
  parameter int RADIUS_BITS = mer_pkg::RADIUS_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  mer_cmd_if.sink   cmd,
  mer_pix_if.source pix
);
  import mer_pkg::*;

  localparam int PIX_BITS  = COORD_BITS + 2;
  localparam int SQ_BITS   = 2 * RADIUS_BITS;
  // multiplier operand widths: A carries squares of coordinates, B the squared radii or tx
  localparam int SA = (2 * COORD_BITS + 2 > SQ_BITS) ? 2 * COORD_BITS + 2 : SQ_BITS;
  localparam int SB = (SQ_BITS > COORD_BITS + 1) ? SQ_BITS : COORD_BITS + 1;
  localparam int PROD_BITS = SA + SB;
  localparam int Q_BITS    = PROD_BITS + 2;

  localparam logic       ACT_START = 1'b0;
  localparam logic [1:0] LAST_PIX  = 2'd3;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_R1   = 2'd1,
    PH_R2   = 2'd2
  } phase_t;

  typedef enum logic [4:0] {
    S_READY, S_SQX, S_SQY, S_RXRY, S_INITD,
    S_CMP_A, S_CMP_B, S_CMP_C,
    S_E2_TX, S_E2_A, S_E2_YM, S_E2_B, S_E2_RR, S_E2_FIN,
    S_EMIT, S_UPD_A, S_UPD_B, S_UPD_C, S_UPD_D
  } state_t;

  state_t                    state;
  phase_t                    phase;
  logic [COORD_BITS-1:0]     centre_x;
  logic [COORD_BITS-1:0]     centre_y;
  logic [RADIUS_BITS-1:0]    rad_x;
  logic [RADIUS_BITS-1:0]    rad_y;
  logic [SQ_BITS-1:0]        rx_sq;
  logic [SQ_BITS-1:0]        ry_sq;
  logic [COORD_BITS-1:0]     point_x;
  logic [COORD_BITS-1:0]     point_y;
  logic [DEC_BITS-1:0]       decision;
  logic [PROD_BITS-1:0]      cmp_lhs;
  logic signed [Q_BITS-1:0]  acc;
  logic                      add_x;
  logic                      sub_y;
  logic [1:0]                pix_cnt;
  logic                      out_valid;
  logic signed [PIX_BITS-1:0] out_x;
  logic signed [PIX_BITS-1:0] out_y;
  logic                      out_last;
  logic                      out_done;

  // shared multiplier
  logic [SA-1:0]        mul_a;
  logic [SB-1:0]        mul_b;
  logic [PROD_BITS-1:0] prod;

  logic [COORD_BITS:0]   tx;
  logic [COORD_BITS-1:0] ym;
  logic                  dec_neg;
  logic                  emit_last;
  logic                  out_free;
  logic signed [Q_BITS-1:0] q_full;
  logic signed [Q_BITS-1:0] q_adj;
  logic signed [Q_BITS-1:0] q_div;
  logic [PIX_BITS-1:0]   px_plus, px_minus, py_plus, py_minus;
  logic [PIX_BITS-1:0]   px_sel, py_sel;

  assign tx        = {point_x, 1'b1};
  // |y - 1|; at y = 0 the square still comes out as 1
  assign ym        = (point_y == '0) ? COORD_BITS'(1) : point_y - COORD_BITS'(1);
  assign dec_neg   = decision[DEC_BITS-1];
  assign emit_last = (phase == PH_R2) && (point_y == '0);
  assign out_free  = !out_valid || pix.ready;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      S_SQX:   begin mul_a = SA'(rad_x);   mul_b = SB'(rad_x); end
      S_SQY:   begin mul_a = SA'(rad_y);   mul_b = SB'(rad_y); end
      S_RXRY:  begin mul_a = SA'(rad_y);   mul_b = SB'(rx_sq); end
      S_CMP_A: begin mul_a = SA'(point_x); mul_b = SB'(ry_sq); end
      S_CMP_B: begin mul_a = SA'(point_y); mul_b = SB'(rx_sq); end
      S_E2_TX: begin mul_a = SA'(tx);      mul_b = SB'(tx);    end
      S_E2_A:  begin mul_a = SA'(prod);    mul_b = SB'(ry_sq); end
      S_E2_YM: begin mul_a = SA'(ym);      mul_b = SB'(ym);    end
      S_E2_B:  begin mul_a = SA'(prod);    mul_b = SB'(rx_sq); end
      S_E2_RR: begin mul_a = SA'(ry_sq);   mul_b = SB'(rx_sq); end
      S_UPD_B: begin mul_a = SA'(point_x); mul_b = SB'(ry_sq); end
      S_UPD_C: begin mul_a = SA'(point_y); mul_b = SB'(rx_sq); end
      default: begin mul_a = '0;           mul_b = '0;         end
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= PROD_BITS'(mul_a) * PROD_BITS'(mul_b);
  end

  // region 2 start value: quarter units, truncated toward zero
  always_comb begin
    q_full = acc - (Q_BITS'(prod) << 2);
    q_adj  = q_full + (q_full[Q_BITS-1] ? Q_BITS'(3) : Q_BITS'(0));
    q_div  = q_adj >>> 2;
  end

  always_comb begin
    px_plus  = PIX_BITS'(centre_x) + PIX_BITS'(point_x);
    px_minus = PIX_BITS'(centre_x) - PIX_BITS'(point_x);
    py_plus  = PIX_BITS'(centre_y) + PIX_BITS'(point_y);
    py_minus = PIX_BITS'(centre_y) - PIX_BITS'(point_y);
    px_sel   = pix_cnt[0] ? px_minus : px_plus;
    py_sel   = (pix_cnt == 2'd1 || pix_cnt == 2'd2) ? py_plus : py_minus;
  end

  assign cmd.ready        = (state == S_READY);
  assign pix.valid        = out_valid;
  assign pix.pixel_x      = out_x;
  assign pix.pixel_y      = out_y;
  assign pix.point_last   = out_last;
  assign pix.ellipse_done = out_done;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_READY;
      phase     <= PH_IDLE;
      pix_cnt   <= '0;
      out_valid <= 1'b0;
    end else begin
      // in S_EMIT a free output register is always reloaded below
      if (pix.ready && state != S_EMIT) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_READY: begin
          if (cmd.valid) begin
            if (cmd.action == ACT_START) begin
              centre_x <= cmd.centre_x;
              centre_y <= cmd.centre_y;
              rad_x    <= cmd.radius_x;
              rad_y    <= cmd.radius_y;
              state    <= S_SQX;
            end else begin
              priority case (phase)
                PH_R1:   state <= S_CMP_A;
                PH_R2:   state <= S_EMIT;
                default: state <= S_READY;
              endcase
            end
          end
        end
        S_SQX: state <= S_SQY;
        S_SQY: begin
          rx_sq <= SQ_BITS'(prod);
          state <= S_RXRY;
        end
        S_RXRY: begin
          ry_sq <= SQ_BITS'(prod);
          state <= S_INITD;
        end
        S_INITD: begin
          decision <= DEC_BITS'(ry_sq) - DEC_BITS'(prod) + DEC_BITS'(rx_sq >> 2);
          point_x  <= '0;
          point_y  <= COORD_BITS'(rad_y);
          phase    <= PH_R1;
          state    <= S_READY;
        end
        S_CMP_A: state <= S_CMP_B;
        S_CMP_B: begin
          cmp_lhs <= prod;
          state   <= S_CMP_C;
        end
        S_CMP_C: begin
          // x*ry^2 < y*rx^2 keeps us in region 1
          state <= (cmp_lhs < prod) ? S_EMIT : S_E2_TX;
        end
        S_E2_TX: state <= S_E2_A;
        S_E2_A:  state <= S_E2_YM;
        S_E2_YM: begin
          acc   <= Q_BITS'(prod);
          state <= S_E2_B;
        end
        S_E2_B: state <= S_E2_RR;
        S_E2_RR: begin
          acc   <= acc + (Q_BITS'(prod) << 2);
          state <= S_E2_FIN;
        end
        S_E2_FIN: begin
          decision <= DEC_BITS'(q_div);
          phase    <= PH_R2;
          state    <= S_EMIT;
        end
        S_EMIT: begin
          if (out_free) begin
            out_valid <= 1'b1;
            out_x     <= px_sel;
            out_y     <= py_sel;
            out_last  <= (pix_cnt == LAST_PIX);
            out_done  <= (pix_cnt == LAST_PIX) && emit_last;
            pix_cnt   <= pix_cnt + 2'd1;
            if (pix_cnt == LAST_PIX) begin
              if (emit_last) begin
                phase <= PH_IDLE;
                state <= S_READY;
              end else begin
                state <= S_UPD_A;
              end
            end
          end
        end
        S_UPD_A: begin
          // move the point and fold in the constant term; product terms follow
          if (phase == PH_R1) begin
            point_x  <= point_x + COORD_BITS'(1);
            add_x    <= 1'b1;
            sub_y    <= !dec_neg;
            if (!dec_neg) begin
              point_y <= point_y - COORD_BITS'(1);
            end
            decision <= decision + DEC_BITS'(ry_sq);
          end else begin
            point_y <= point_y - COORD_BITS'(1);
            sub_y   <= 1'b1;
            if (!dec_neg && decision != '0) begin
              add_x    <= 1'b0;
              decision <= decision + DEC_BITS'(rx_sq);
            end else begin
              point_x  <= point_x + COORD_BITS'(1);
              add_x    <= 1'b1;
              decision <= decision - DEC_BITS'(rx_sq);
            end
          end
          state <= S_UPD_B;
        end
        S_UPD_B: state <= S_UPD_C;
        S_UPD_C: begin
          if (add_x) begin
            decision <= decision + (DEC_BITS'(prod) << 1);
          end
          state <= S_UPD_D;
        end
        S_UPD_D: begin
          if (sub_y) begin
            decision <= decision - (DEC_BITS'(prod) << 1);
          end
          state <= S_READY;
        end
        default: state <= S_READY;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_emit_keeps_decision: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT) |=> $stable(decision))
    else $error("decision changed while pixels were being emitted");

  a_region2_entry: assert property (@(posedge clk) disable iff (rst)
    (state == S_E2_FIN) |=> (phase == PH_R2) && (state == S_EMIT))
    else $error("region 2 entry did not go on to emit the point");

  a_emit_starts_aligned: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT) && ($past(state) != S_EMIT) |-> (pix_cnt == '0))
    else $error("pixel counter not at first pixel when a point starts");
`endif

endmodule
